// ===== rtl/pressure_temp_compensation_defines.svh =====
// ----------------------------------------------------------------------------
// pressure_temp_compensation_defines
// assertion macros shared by the compensation block
// ----------------------------------------------------------------------------
`ifndef PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define PTC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition in one cycle implies a condition in the next
`define PTC_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// types, constants and the divider step of the compensation pipeline
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int DIV_STEPS  = 64;
    localparam int DIV_FIRST  = 10;
    localparam int POST_FIRST = DIV_FIRST + DIV_STEPS + 1;
    localparam int NUM_STAGES = POST_FIRST + 7;
    localparam int IN_WIDTH   = 40;
    localparam int OUT_WIDTH  = 80;

    localparam logic signed [33:0] FINE_OFFSET = 34'sd128000;
    localparam logic [20:0]        PRESS_FULL  = 21'd1048576;
    localparam logic [11:0]        DIV_SCALE   = 12'd3125;
    localparam logic signed [35:0] TEMP_ROUND  = 36'sd128;
    localparam logic signed [35:0] TEMP_MUL    = 36'sd5;
    localparam int                 BIAS_SHIFT  = 47;
    localparam int                 DIVR_SHIFT  = 33;

    typedef enum logic [1:0] {
        REG_TEMP_COEFFS = 2'd0,
        REG_PRESS_LOW   = 2'd1,
        REG_PRESS_HIGH  = 2'd2,
        REG_PRESS_NINE  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic        zero;
        logic        neg;
        logic [30:0] ud;
        logic [30:0] rem;
        logic [63:0] dvd;
    } div_stage_t;

    typedef struct packed {
        logic signed [15:0] temp;
        logic signed [31:0] fine;
    } carry_t;

    // one restoring step: quotient bits shift in at the bottom of dvd
    function automatic div_stage_t div_step(input div_stage_t d);
        div_stage_t  r;
        logic [31:0] sh;
        logic [31:0] dif;
        r   = d;
        sh  = {d.rem, d.dvd[63]};
        dif = sh - {1'b0, d.ud};
        if (sh >= {1'b0, d.ud})
        begin
            r.rem = dif[30:0];
            r.dvd = {d.dvd[62:0], 1'b1};
        end
        else
        begin
            r.rem = sh[30:0];
            r.dvd = {d.dvd[62:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ===== rtl/pressure_temp_compensation.sv =====
// ----------------------------------------------------------------------------
// pressure_temp_compensation: 64-bit integer temperature and pressure compensation
// 82 register stages between the input and the output
// one request per cycle sustained while the output is not stalled; the 64 restoring divider steps set the depth
// an output stall freezes every stage; rst_n clears valid bits and coefficients
// ----------------------------------------------------------------------------
`include "pressure_temp_compensation_defines.svh"

module pressure_temp_compensation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [ptc_pkg::IN_WIDTH-1:0]  s_tdata,  // raw_temperature, raw_pressure
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [ptc_pkg::OUT_WIDTH-1:0] m_tdata,  // temperature_centi, fine_temperature,
                                                    // pressure_q24_8
    output logic        m_tuser,                    // pressure_valid
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import ptc_pkg::*;

    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_nine_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_coeffs_reg <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
            press_nine_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TEMP_COEFFS: temp_coeffs_reg <= cfg_data[47:0];
                REG_PRESS_LOW:   press_low_reg   <= cfg_data;
                REG_PRESS_HIGH:  press_high_reg  <= cfg_data;
                REG_PRESS_NINE:  press_nine_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [15:0]        t1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [15:0]        p1;
    assign t1 = temp_coeffs_reg[15:0];
    assign t2 = temp_coeffs_reg[31:16];
    assign t3 = temp_coeffs_reg[47:32];
    assign p1 = press_low_reg[15:0];
    assign p2 = press_low_reg[31:16];
    assign p3 = press_low_reg[47:32];
    assign p4 = press_low_reg[63:48];
    assign p5 = press_high_reg[15:0];
    assign p6 = press_high_reg[31:16];
    assign p7 = press_high_reg[47:32];
    assign p8 = press_high_reg[63:48];
    assign p9 = press_nine_reg;

    // pipeline control: every stage moves together
    logic [NUM_STAGES-1:0] vld_reg;
    logic                  adv;
    assign adv      = !vld_reg[NUM_STAGES-1] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NUM_STAGES-2:0], s_tvalid};
    end

    // ---------------- temperature ----------------
    logic [19:0]        at_reg;
    logic [19:0]        ap_reg [0:7];
    logic signed [34:0] mul1_reg;
    logic signed [35:0] sq4_reg;
    logic signed [23:0] tv1_reg;
    logic signed [39:0] t3m_reg;
    logic signed [31:0] fine_reg;
    carry_t             car_reg [4:NUM_STAGES-1];

    logic signed [18:0] d3;
    logic signed [17:0] d4;
    logic signed [34:0] mul1_next;
    logic signed [35:0] sq4_next;
    logic signed [23:0] tv1_next;
    logic signed [39:0] t3m_next;
    logic signed [31:0] fine_next;
    logic signed [35:0] tcw;
    logic signed [15:0] temp_next;

    always_comb
    begin
        d3        = $signed({2'b0, at_reg[19:3]}) - $signed({2'b0, t1, 1'b0});
        d4        = $signed({2'b0, at_reg[19:4]}) - $signed({2'b0, t1});
        mul1_next = d3 * t2;
        sq4_next  = d4 * d4;
        tv1_next  = mul1_reg[34:11];
        t3m_next  = (sq4_reg >>> 12) * t3;
        fine_next = tv1_reg + $signed(t3m_reg[39:14]);
        tcw       = (fine_reg * TEMP_MUL + TEMP_ROUND) >>> 8;
        if (tcw > 36'sd32767)
            temp_next = 16'sh7FFF;
        else if (tcw < -36'sd32768)
            temp_next = 16'sh8000;
        else
            temp_next = tcw[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            at_reg    <= s_tdata[19:0];
            ap_reg[0] <= s_tdata[39:20];
            mul1_reg  <= mul1_next;
            sq4_reg   <= sq4_next;
            tv1_reg   <= tv1_next;
            t3m_reg   <= t3m_next;
            fine_reg  <= fine_next;
            car_reg[4] <= '{temp: temp_next, fine: fine_reg};
        end
    end

    genvar gi;
    generate
        for (gi = 1; gi < 8; gi++)
        begin : g_ap
            always_ff @(posedge clk)
            begin
                if (adv)
                    ap_reg[gi] <= ap_reg[gi-1];
            end
        end
        for (gi = 5; gi < NUM_STAGES; gi++)
        begin : g_car
            always_ff @(posedge clk)
            begin
                if (adv)
                    car_reg[gi] <= car_reg[gi-1];
            end
        end
    endgenerate

    // ---------------- pressure terms ----------------
    logic signed [33:0] v1_reg;
    logic [63:0]        vsq_reg;
    logic signed [49:0] vp5_reg, vp2_reg, vp5b_reg, vp2b_reg;
    logic [63:0]        a6_reg, a3_reg;
    logic [63:0]        v2_reg, u_reg;
    logic [63:0]        m1_reg, nb_reg;
    logic [30:0]        dv_reg;
    logic [63:0]        num_reg;

    logic signed [33:0] v1_next;
    logic signed [67:0] sq68;
    logic signed [49:0] vp5_next, vp2_next;
    logic signed [63:0] vsq_s;
    logic signed [79:0] a6w, a3w;
    logic [63:0]        a3s;
    logic [63:0]        v2_next, u_next;
    logic [79:0]        m1w;
    logic [20:0]        pr;
    logic [63:0]        nb_next;
    logic [75:0]        numw;

    always_comb
    begin
        v1_next  = fine_reg - FINE_OFFSET;
        sq68     = v1_reg * v1_reg;
        vp5_next = v1_reg * p5;
        vp2_next = v1_reg * p2;
        vsq_s    = vsq_reg;
        a6w      = vsq_s * p6;
        a3w      = vsq_s * p3;
        a3s      = $signed(a3_reg) >>> 8;
        v2_next  = a6_reg + (64'(vp5b_reg) << 17) + (64'(p4) << 35);
        u_next   = a3s + (64'(vp2b_reg) << 12) + (64'd1 << BIAS_SHIFT);
        m1w      = u_reg * p1;
        pr       = PRESS_FULL - {1'b0, ap_reg[7]};
        nb_next  = ({43'b0, pr} << 31) - v2_reg;
        numw     = nb_reg * DIV_SCALE;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v1_reg   <= v1_next;
            vsq_reg  <= sq68[63:0];
            vp5_reg  <= vp5_next;
            vp2_reg  <= vp2_next;
            a6_reg   <= a6w[63:0];
            a3_reg   <= a3w[63:0];
            vp5b_reg <= vp5_reg;
            vp2b_reg <= vp2_reg;
            v2_reg   <= v2_next;
            u_reg    <= u_next;
            m1_reg   <= m1w[63:0];
            nb_reg   <= nb_next;
            dv_reg   <= m1_reg[63:DIVR_SHIFT];
            num_reg  <= numw[63:0];
        end
    end

    // ---------------- divider ----------------
    div_stage_t div_reg [0:DIV_STEPS];
    div_stage_t div_load;

    always_comb
    begin
        div_load.zero = (dv_reg == '0);
        div_load.neg  = num_reg[63] ^ dv_reg[30];
        div_load.ud   = dv_reg[30] ? (31'd0 - dv_reg) : dv_reg;
        div_load.rem  = '0;
        div_load.dvd  = num_reg[63] ? (64'd0 - num_reg) : num_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            div_reg[0] <= div_load;
    end

    generate
        for (gi = 1; gi <= DIV_STEPS; gi++)
        begin : g_div
            always_ff @(posedge clk)
            begin
                if (adv)
                    div_reg[gi] <= div_step(div_reg[gi-1]);
            end
        end
    endgenerate

    // ---------------- correction terms and output ----------------
    logic [63:0] pp_reg [0:3];
    logic [5:0]  zp_reg;
    logic [63:0] ps_reg, a_reg;
    logic [63:0] w2_reg [0:2];
    logic [63:0] ll_reg;
    logic [31:0] lh_reg, hl_reg;
    logic [63:0] w1_reg, s_reg, f_reg;
    logic [31:0] press_reg;
    logic        pvalid_reg;

    logic signed [63:0] ps_s;
    logic signed [79:0] aw, w2w;
    logic [63:0]        w2lo, w2_next;
    logic [63:0]        ll_next;
    logic [31:0]        lh_next, hl_next;
    logic [63:0]        prod, w1_next;
    logic [63:0]        s8, p7x;
    logic [31:0]        press_next;

    always_comb
    begin
        ps_s    = $signed(pp_reg[0]) >>> 13;
        aw      = p9 * ps_s;
        w2w     = p8 * $signed(pp_reg[0]);
        w2lo    = w2w[63:0];
        w2_next = $signed(w2lo) >>> 19;
        ll_next = a_reg[31:0] * ps_reg[31:0];
        lh_next = a_reg[31:0] * ps_reg[63:32];
        hl_next = a_reg[63:32] * ps_reg[31:0];
        prod    = ll_reg + {lh_reg + hl_reg, 32'b0};
        w1_next = $signed(prod) >>> 25;
        s8      = $signed(s_reg) >>> 8;
        p7x     = {{48{p7[15]}}, p7} << 4;
        if (zp_reg[5] || f_reg[63])
            press_next = '0;
        else if (|f_reg[62:32])
            press_next = 32'hFFFF_FFFF;
        else
            press_next = f_reg[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pp_reg[0]  <= div_reg[DIV_STEPS].neg ? (64'd0 - div_reg[DIV_STEPS].dvd)
                                                 : div_reg[DIV_STEPS].dvd;
            zp_reg     <= {zp_reg[4:0], div_reg[DIV_STEPS].zero};
            pp_reg[1]  <= pp_reg[0];
            ps_reg     <= ps_s;
            a_reg      <= aw[63:0];
            w2_reg[0]  <= w2_next;
            pp_reg[2]  <= pp_reg[1];
            ll_reg     <= ll_next;
            lh_reg     <= lh_next;
            hl_reg     <= hl_next;
            w2_reg[1]  <= w2_reg[0];
            pp_reg[3]  <= pp_reg[2];
            w1_reg     <= w1_next;
            w2_reg[2]  <= w2_reg[1];
            s_reg      <= pp_reg[3] + w1_reg + w2_reg[2];
            f_reg      <= s8 + p7x;
            press_reg  <= press_next;
            pvalid_reg <= !zp_reg[5];
        end
    end

    assign m_tvalid = vld_reg[NUM_STAGES-1];
    assign m_tdata  = {press_reg, car_reg[NUM_STAGES-1].fine, car_reg[NUM_STAGES-1].temp};
    assign m_tuser  = pvalid_reg;

    `PTC_ASSERT_ALWAYS(a_zero_div_press, !(m_tvalid && !m_tuser) || (m_tdata[79:48] == 32'd0), "pressure not forced to zero on zero divisor")
    `PTC_ASSERT_NEXT(a_stall_freeze, !adv, $stable(vld_reg), "pipeline moved during output stall")
    `PTC_ASSERT_NEXT(a_take_request, adv && s_tvalid, vld_reg[0], "accepted request lost at entry")

endmodule
